// ----- hw/rtl/tte_pkg.sv -----
`default_nettype none

package tte_pkg;

   // Defaults for the build-time parameters of the top level.
   localparam int DEFAULT_MAX_STOPS = 4;
   localparam int DEFAULT_COL_BITS  = 16;

   // Fixed field widths of the ports.
   localparam int BYTE_BITS      = 8;
   localparam int RUN_BITS       = 16;
   localparam int REG_BITS       = 16;
   localparam int COUNT_BITS     = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int NUM_STOP_REGS  = 4;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_LEAD_ONLY  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TAB_PITCH  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STOP_COUNT = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STOP_ZERO  = 3'd3;

   // Register reset values.
   localparam logic [REG_BITS-1:0] DEFAULT_REPEAT = 16'd8;

   // Character codes.
   localparam logic [BYTE_BITS-1:0] CHAR_BS    = 8'h08;
   localparam logic [BYTE_BITS-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_BITS-1:0] CHAR_NL    = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CHAR_VT    = 8'h0B;
   localparam logic [BYTE_BITS-1:0] CHAR_FF    = 8'h0C;
   localparam logic [BYTE_BITS-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CHAR_SPACE = 8'h20;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_LOAD
   } tte_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic eval;
      logic div_step;
      logic div_finish;
      logic load;
   } tte_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;
      logic div_done;
      logic out_free;
   } tte_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/tte_ctrl.sv -----
`default_nettype none

module tte_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire tte_pkg::tte_status_type status,
   output tte_pkg::tte_cmd_type         cmd
);

   tte_pkg::tte_state_type state_ff;
   tte_pkg::tte_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tte_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      case (state_ff)
         tte_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = tte_pkg::ST_EVAL;
            end
         end
         tte_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            if (status.need_div) begin
               state_in = tte_pkg::ST_DIV;
            end else begin
               state_in = tte_pkg::ST_LOAD;
            end
         end
         tte_pkg::ST_DIV: begin
            if (status.div_done) begin
               cmd.div_finish = 1'b1;
               state_in       = tte_pkg::ST_LOAD;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         tte_pkg::ST_LOAD: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = tte_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tte_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/tte_datapath.sv -----
`default_nettype none

module tte_datapath #(
   parameter int MAX_STOPS = tte_pkg::DEFAULT_MAX_STOPS,
   parameter int COL_BITS  = tte_pkg::DEFAULT_COL_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire tte_pkg::tte_cmd_type                 cmd,
   output tte_pkg::tte_status_type                   status,
   input  wire logic [tte_pkg::BYTE_BITS-1:0]        req_in_byte,
   input  wire logic                                 req_new_file,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [tte_pkg::BYTE_BITS-1:0]             rsp_out_byte,
   output logic [tte_pkg::RUN_BITS-1:0]              rsp_run_length,
   input  wire logic                                 csr_valid,
   input  wire logic [tte_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [tte_pkg::REG_BITS-1:0]         csr_wdata
);

   localparam int WB =
      ((COL_BITS > tte_pkg::REG_BITS) ? COL_BITS : tte_pkg::REG_BITS) + 1;
   localparam int CNT_BITS     = $clog2(MAX_STOPS + 1);
   localparam int DIV_CNT_BITS = $clog2(COL_BITS + 1);
   localparam logic [COL_BITS-1:0] COL_MAX = '1;

   // Configuration registers.
   logic                              lead_only_ff;
   logic [tte_pkg::REG_BITS-1:0]      tab_pitch_ff;
   logic [tte_pkg::COUNT_BITS-1:0]    stop_count_ff;
   logic [tte_pkg::REG_BITS-1:0]      stops_ff [MAX_STOPS];

   // Line state and the item at work.
   logic [COL_BITS-1:0]               column_ff, column_in;
   logic                              blank_ff, blank_in;
   logic [tte_pkg::BYTE_BITS-1:0]     byte_ff;
   logic [WB-1:0]                     stop_ff, stop_in;

   // Remainder unit.
   logic [COL_BITS-1:0]               dividend_ff, dividend_in;
   logic [tte_pkg::REG_BITS-1:0]      rem_ff, rem_in;
   logic [DIV_CNT_BITS-1:0]           div_cnt_ff, div_cnt_in;

   // Output register.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [tte_pkg::BYTE_BITS-1:0]     out_byte_ff, out_byte_in;
   logic [tte_pkg::RUN_BITS-1:0]      run_ff, run_in;

   // Combinational terms.
   logic [CNT_BITS-1:0]               n_eff;
   logic [WB-1:0]                     col_w;
   logic                              hit;
   logic [WB-1:0]                     hit_stop;
   logic [WB-1:0]                     base;
   logic [WB-1:0]                     diff_w;
   logic                              expand;
   logic [tte_pkg::REG_BITS:0]        trial;
   logic [WB-1:0]                     clip;
   logic                              advance;
   logic [WB-1:0]                     run_w;

   function automatic logic is_white(input logic [tte_pkg::BYTE_BITS-1:0] c);
      is_white = (c == tte_pkg::CHAR_SPACE) || (c == tte_pkg::CHAR_TAB) ||
                 (c == tte_pkg::CHAR_NL) || (c == tte_pkg::CHAR_VT) ||
                 (c == tte_pkg::CHAR_FF) || (c == tte_pkg::CHAR_CR);
   endfunction

   // Scalar configuration registers; writes to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_only_ff  <= 1'b0;
         tab_pitch_ff  <= tte_pkg::DEFAULT_REPEAT;
         stop_count_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == tte_pkg::REG_LEAD_ONLY) begin
            lead_only_ff <= csr_wdata[0];
         end
         if (csr_index == tte_pkg::REG_TAB_PITCH) begin
            tab_pitch_ff <= csr_wdata;
         end
         if (csr_index == tte_pkg::REG_STOP_COUNT) begin
            stop_count_ff <= csr_wdata[tte_pkg::COUNT_BITS-1:0];
         end
      end
   end

   // Stop registers; entries with no register behind them stay zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_STOPS; i++) begin
            stops_ff[i] <= '0;
         end
      end else if (csr_valid) begin
         for (int i = 0; i < MAX_STOPS; i++) begin
            if ((i < tte_pkg::NUM_STOP_REGS) &&
                (32'(csr_index) == 32'(tte_pkg::REG_STOP_ZERO) + 32'(i))) begin
               stops_ff[i] <= csr_wdata;
            end
         end
      end
   end

   // Stop search: first explicit stop beyond the column, and the base of the
   // repeating stops.
   always_comb begin
      if (32'(stop_count_ff) > 32'(MAX_STOPS)) begin
         n_eff = CNT_BITS'(MAX_STOPS);
      end else begin
         n_eff = CNT_BITS'(stop_count_ff);
      end
      col_w    = WB'(column_ff);
      hit      = 1'b0;
      hit_stop = '0;
      for (int i = MAX_STOPS - 1; i >= 0; i--) begin
         if ((i < int'(n_eff)) && (WB'(stops_ff[i]) > col_w)) begin
            hit      = 1'b1;
            hit_stop = WB'(stops_ff[i]);
         end
      end
      base = '0;
      for (int i = 0; i < MAX_STOPS; i++) begin
         if (int'(n_eff) == i + 1) begin
            base = WB'(stops_ff[i]);
         end
      end
      if (col_w < base) begin
         base = '0;
      end
      diff_w = col_w - base;
      expand = (byte_ff == tte_pkg::CHAR_TAB) && (!lead_only_ff || blank_ff);
   end

   // One restoring step of the remainder by the repeat size.
   always_comb begin
      trial = {rem_ff, dividend_ff[COL_BITS-1]};
      if (trial >= {1'b0, tab_pitch_ff}) begin
         rem_in = tte_pkg::REG_BITS'(trial - {1'b0, tab_pitch_ff});
      end else begin
         rem_in = trial[tte_pkg::REG_BITS-1:0];
      end
   end

   // Stop clipped to the column range, and the run that reaches it.
   always_comb begin
      if (stop_ff > WB'(COL_MAX)) begin
         clip = WB'(COL_MAX);
      end else begin
         clip = stop_ff;
      end
      advance = clip > col_w;
      run_w   = advance ? (clip - col_w) : WB'(1);
   end

   // Next values of the item registers and the remainder unit.
   always_comb begin
      dividend_in = dividend_ff;
      div_cnt_in  = div_cnt_ff;
      stop_in     = stop_ff;
      if (cmd.eval) begin
         if (hit) begin
            stop_in = hit_stop;
         end else begin
            stop_in = col_w + WB'(1);
         end
         dividend_in = diff_w[COL_BITS-1:0];
         div_cnt_in  = DIV_CNT_BITS'(COL_BITS);
      end else if (cmd.div_step) begin
         dividend_in = dividend_ff << 1;
         div_cnt_in  = div_cnt_ff - DIV_CNT_BITS'(1);
      end else if (cmd.div_finish) begin
         stop_in = col_w + WB'(tab_pitch_ff) - WB'(rem_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else begin
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         byte_ff <= req_in_byte;
      end
      if (cmd.eval) begin
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
      end
      dividend_ff <= dividend_in;
      stop_ff     <= stop_in;
   end

   // Column and blank-only flag: the new-file flag acts on transfer, the
   // byte itself when its result is loaded.
   always_comb begin
      column_in   = column_ff;
      blank_in    = blank_ff;
      out_byte_in = out_byte_ff;
      run_in      = run_ff;
      if (cmd.capture && req_new_file) begin
         column_in = '0;
         blank_in  = 1'b1;
      end
      if (cmd.load) begin
         if (expand) begin
            out_byte_in = tte_pkg::CHAR_SPACE;
            run_in      = run_w[tte_pkg::RUN_BITS-1:0];
            if (advance) begin
               column_in = clip[COL_BITS-1:0];
            end
         end else begin
            out_byte_in = byte_ff;
            run_in      = tte_pkg::RUN_BITS'(1);
            if (byte_ff == tte_pkg::CHAR_NL) begin
               column_in = '0;
               blank_in  = 1'b1;
            end else if (byte_ff == tte_pkg::CHAR_BS) begin
               if (column_ff != '0) begin
                  column_in = column_ff - COL_BITS'(1);
               end
            end else if (byte_ff == tte_pkg::CHAR_CR) begin
               column_in = '0;
            end else begin
               if (column_ff != COL_MAX) begin
                  column_in = column_ff + COL_BITS'(1);
               end
               if (!is_white(byte_ff)) begin
                  blank_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         blank_ff  <= 1'b1;
      end else begin
         column_ff <= column_in;
         blank_ff  <= blank_in;
      end
   end

   // Output register: holds the result until the far side takes it.
   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      run_ff      <= run_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_run_length = run_ff;

   assign status.need_div = expand && !hit && (tab_pitch_ff != '0);
   assign status.div_done = (div_cnt_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // A result is only loaded into a free output register.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over one not yet transferred");

   // A loaded result is offered in the next cycle.
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid_ff)
      else $error("loaded result not offered");

   // The remainder unit never steps past its last bit.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (div_cnt_ff != '0))
      else $error("remainder step with no bits left");

   // An expanded tab always comes out as spaces.
   a_tab_space: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && expand) |=> (out_byte_ff == tte_pkg::CHAR_SPACE))
      else $error("expanded tab not emitted as space");

endmodule

`default_nettype wire

// ----- hw/rtl/tab_to_space_expander_unit.sv -----
`default_nettype none

// Tab-to-space expander. Each text byte transferred on the req_ channel gives
// exactly one result on the rsp_ channel: a byte and a run length. Tabs become
// a run of spaces up to the next stop (explicit stops first, then repeating
// stops spaced by the repeat size from the last explicit one); other bytes
// pass with run length 1 and move the column. One item is worked at a time.
// An ordinary byte, or a tab that lands on an explicit stop or has repeat size
// zero, goes from transfer through the evaluate and load states to the output
// register. A tab that falls into the repeating stops also passes through the
// bit-serial remainder unit, which works one column bit per cycle. A
// finished result waits in the output register while the next byte is taken.
// Configuration registers are written through the csr_ channel, which is
// always ready, and should only be changed while no item is at work.
module tab_to_space_expander_unit #(
   parameter int MAX_STOPS = tte_pkg::DEFAULT_MAX_STOPS,
   parameter int COL_BITS  = tte_pkg::DEFAULT_COL_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [tte_pkg::BYTE_BITS-1:0]       req_in_byte,
   input  wire logic                                req_new_file,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [tte_pkg::BYTE_BITS-1:0]            rsp_out_byte,
   output logic [tte_pkg::RUN_BITS-1:0]             rsp_run_length,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tte_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [tte_pkg::REG_BITS-1:0]        csr_wdata
);

   tte_pkg::tte_cmd_type    cmd;
   tte_pkg::tte_status_type status;

   // Register writes complete in the cycle they are offered.
   assign csr_ready = 1'b1;

   // Sequencer.
   tte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Registers, stop search, remainder unit and output register.
   tte_datapath #(
      .MAX_STOPS (MAX_STOPS),
      .COL_BITS  (COL_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_in_byte    (req_in_byte),
      .req_new_file   (req_new_file),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_length (rsp_run_length),
      .csr_valid      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

endmodule

`default_nettype wire
